// ===== rtl/srisc_pkg.sv =====
// srisc_pkg: opcodes, modifiers, register numbers, actions, sequencer states, request and result types for the core
// no dependencies
`default_nettype none
package srisc_pkg;
	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_EXEC = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_MUL  = 5'd2;
	localparam logic [4:0] OP_DIV  = 5'd3;
	localparam logic [4:0] OP_MOD  = 5'd4;
	localparam logic [4:0] OP_CMP  = 5'd5;
	localparam logic [4:0] OP_AND  = 5'd6;
	localparam logic [4:0] OP_OR   = 5'd7;
	localparam logic [4:0] OP_NOT  = 5'd8;
	localparam logic [4:0] OP_MOV  = 5'd9;
	localparam logic [4:0] OP_LSL  = 5'd10;
	localparam logic [4:0] OP_LSR  = 5'd11;
	localparam logic [4:0] OP_ASR  = 5'd12;
	localparam logic [4:0] OP_LD   = 5'd14;
	localparam logic [4:0] OP_ST   = 5'd15;
	localparam logic [4:0] OP_BEQ  = 5'd16;
	localparam logic [4:0] OP_BGT  = 5'd17;
	localparam logic [4:0] OP_B    = 5'd18;
	localparam logic [4:0] OP_CALL = 5'd19;
	localparam logic [4:0] OP_RET  = 5'd20;
	localparam logic [4:0] OP_HALT = 5'd31;

	localparam logic [1:0] MOD_SEXT = 2'd0;
	localparam logic [1:0] MOD_HIGH = 2'd2;
	localparam logic [3:0] REG_LINK = 4'd15;
	localparam logic [3:0] REG_SP   = 4'd14;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_EXEC,
		ST_DIV,
		ST_MEM,
		ST_MEMWAIT,
		ST_WB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] exec_pc;
		logic [31:0] next_pc;
		logic        reg_written;
		logic [3:0]  dest_reg;
		logic [31:0] dest_value;
		logic [31:0] read_word_out;
		logic        is_halted;
		logic        divide_fault;
	} result_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] address;
		logic [31:0] word_in;
	} request_t;
endpackage
`default_nettype wire

// ===== rtl/srisc_if.sv =====
// srisc_if: valid/ready channel carrying one payload
// depends on nothing; payload type given as a parameter
`default_nettype none
interface srisc_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/simplerisc_core.sv =====
// simplerisc_core: multi-cycle SimpleRISC core with word memory
// depends on srisc_pkg and srisc_if
// after reset a clearing pass zeroes the memory, no request taken
// load, read and execute while halted pass through fetch, decode and output states;
// execute adds exec and writeback, ld and st also a memory access and its wait
// state, as the single memory port serves fetch, then data access; div and mod with a
// nonzero divisor also pass through the shared one-bit-per-cycle divider
// a result waiting in the output register holds the next request in its output state
`default_nettype none
module simplerisc_core import srisc_pkg::*; #(
	parameter int MEM_BYTES   = 4096,
	parameter int STACK_RESET = 2000
) (
	input  wire logic clk,
	input  wire logic arst_n,
	srisc_if.sink     req,
	srisc_if.source   rsp
);
	localparam int MEM_WORDS = MEM_BYTES / 4;
	localparam int AW = $clog2(MEM_WORDS);

	state_t state_q, state_d;

	logic [31:0] mem [MEM_WORDS];
	logic [31:0] mem_rdata_q;
	logic        mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0] mem_wdata;

	logic [31:0] regs_q [16];
	logic [31:0] pc_q;
	logic        gt_q, eq_q, halt_q;
	logic [AW-1:0] clr_q;
	request_t    req_q;
	logic [31:0] req_addr;
	logic [31:0] inst_q, a_q, b_q, st_q, res_q, next_q;
	logic [31:0] op2, immw, immls;
	logic        wr_q, fault_q;
	logic [3:0]  rd_q;
	result_t     out_q;
	logic        out_v_q;
	logic        out_load;
	logic [31:0] exec_pc_q;
	logic        halt_or_skip_q;

	// divider state
	logic [31:0] dq_q, dr_q, dm_q;
	logic [5:0]  dcnt_q;
	logic        dna_q, dnb_q;

	// instruction fields
	logic [4:0] opc;
	logic       imm_bit;
	logic [1:0] modf;
	logic [31:0] off4;
	assign opc     = inst_q[31:27];
	assign imm_bit = inst_q[26];
	assign modf    = inst_q[17:16];
	assign off4    = {{3{inst_q[26]}}, inst_q[26:0], 2'b00};
	assign req_addr = {20'd0, req_q.address};

	logic start;
	assign req.ready = (state_q == ST_IDLE);
	assign start = req.valid && req.ready;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;
	assign out_load  = (state_q == ST_OUT) && (!out_v_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == AW'(MEM_WORDS - 1)) state_d = ST_IDLE;
			ST_IDLE:    if (start) state_d = ST_FETCH;
			ST_FETCH:   state_d = ST_DECODE;
			ST_DECODE:  state_d = (req_q.action == ACT_EXEC && !halt_q) ? ST_EXEC : ST_OUT;
			ST_EXEC:    state_d = (opc == OP_DIV || opc == OP_MOD) && op2 != 32'd0 ? ST_DIV
				: (opc == OP_LD || opc == OP_ST) ? ST_MEM : ST_WB;
			ST_DIV:     if (dcnt_q == 6'd32) state_d = ST_WB;
			ST_MEM:     state_d = ST_MEMWAIT;
			ST_MEMWAIT: state_d = ST_WB;
			ST_WB:      state_d = ST_OUT;
			ST_OUT:     if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory port control
	logic [31:0] ls_addr;
	assign ls_addr = a_q + immls;
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = req_addr[AW+1:2];
		mem_wdata = req_q.word_in;
		mem_raddr = req_addr[AW+1:2];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 32'd0;
			end
			ST_FETCH: begin
				mem_we = (req_q.action == ACT_LOAD);
				if (req_q.action == ACT_EXEC) mem_raddr = pc_q[AW+1:2];
			end
			ST_MEM: begin
				mem_raddr = ls_addr[AW+1:2];
				mem_waddr = ls_addr[AW+1:2];
				mem_wdata = st_q;
				mem_we    = (opc == OP_ST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	// second operand and immediate widening
	always_comb begin
		immw = {16'd0, inst_q[15:0]};
		if (modf == MOD_SEXT) immw = {{16{inst_q[15]}}, inst_q[15:0]};
		else if (modf == MOD_HIGH) immw = {inst_q[15:0], 16'd0};
		immls = imm_bit ? immw : {16'd0, inst_q[15:0]};
		op2 = imm_bit ? immw : b_q;
	end

	// shared alu
	logic [31:0] alu;
	logic [4:0]  sh;
	assign sh = op2[4:0];
	always_comb begin
		unique case (opc)
			OP_ADD:  alu = a_q + op2;
			OP_SUB:  alu = a_q - op2;
			OP_MUL:  alu = a_q * op2;
			OP_AND:  alu = a_q & op2;
			OP_OR:   alu = a_q | op2;
			OP_NOT:  alu = ~op2;
			OP_MOV:  alu = op2;
			OP_LSL:  alu = a_q << sh;
			OP_LSR:  alu = a_q >> sh;
			OP_ASR:  alu = 32'($signed(a_q) >>> sh);
			OP_CALL: alu = pc_q + 32'd4;
			default: alu = 32'd0;
		endcase
	end

	// execute outcome: write enable, result, next pc and fault
	logic [31:0] ex_next, ex_res;
	logic        ex_wr, ex_fault;
	always_comb begin
		ex_next  = pc_q + 32'd4;
		ex_wr    = 1'b1;
		ex_res   = alu;
		ex_fault = 1'b0;
		unique case (opc)
			OP_DIV, OP_MOD: begin
				if (op2 == 32'd0) begin
					ex_res   = 32'd0;
					ex_fault = 1'b1;
				end
			end
			OP_CMP, OP_ST: ex_wr = 1'b0;
			OP_BEQ: begin
				ex_wr = 1'b0;
				if (eq_q) ex_next = pc_q + off4;
			end
			OP_BGT: begin
				ex_wr = 1'b0;
				if (gt_q) ex_next = pc_q + off4;
			end
			OP_B: begin
				ex_wr   = 1'b0;
				ex_next = pc_q + off4;
			end
			OP_CALL: ex_next = pc_q + off4;
			OP_RET: begin
				ex_wr   = 1'b0;
				ex_next = regs_q[REG_LINK];
			end
			OP_HALT: begin
				ex_wr   = 1'b0;
				ex_next = pc_q;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_NOT, OP_MOV,
			OP_LSL, OP_LSR, OP_ASR, OP_LD: ;
			default: ex_wr = 1'b0;
		endcase
	end

	// restoring divider step
	logic [32:0] dtrial;
	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dm_q};

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
			pc_q    <= '0;
			gt_q    <= 1'b0;
			eq_q    <= 1'b0;
			halt_q  <= 1'b0;
			for (int i = 0; i < 16; i++)
				regs_q[i] <= (i == int'(REG_SP)) ? 32'(STACK_RESET) : 32'd0;
		end else begin
			state_q <= state_d;
			if (out_load) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_IDLE: if (start) req_q <= req.data;
				ST_FETCH: ;
				ST_DECODE: begin
					inst_q  <= mem_rdata_q;
					wr_q    <= 1'b0;
					fault_q <= 1'b0;
					rd_q    <= mem_rdata_q[25:22];
					next_q  <= pc_q;
				end
				ST_EXEC: begin
					next_q  <= ex_next;
					wr_q    <= ex_wr;
					res_q   <= ex_res;
					fault_q <= ex_fault;
					if (opc == OP_CALL) rd_q <= REG_LINK;
					if (opc == OP_HALT) halt_q <= 1'b1;
					if (opc == OP_CMP) begin
						gt_q <= $signed(a_q) > $signed(op2);
						eq_q <= a_q == op2;
					end
					if (opc == OP_DIV || opc == OP_MOD) begin
						dna_q  <= a_q[31];
						dnb_q  <= op2[31];
						dq_q   <= a_q[31] ? -a_q : a_q;
						dm_q   <= op2[31] ? -op2 : op2;
						dr_q   <= '0;
						dcnt_q <= '0;
					end
				end
				ST_DIV: begin
					if (dcnt_q != 6'd32) begin
						dcnt_q <= dcnt_q + 6'd1;
						dq_q   <= {dq_q[30:0], ~dtrial[32]};
						dr_q   <= dtrial[32] ? {dr_q[30:0], dq_q[31]} : dtrial[31:0];
					end else if (opc == OP_MOD)
						res_q <= dna_q ? -dr_q : dr_q;
					else
						res_q <= (dna_q != dnb_q) ? -dq_q : dq_q;
				end
				ST_MEM: ;
				ST_MEMWAIT: if (opc == OP_LD) res_q <= mem_rdata_q;
				ST_WB: begin
					if (wr_q) regs_q[rd_q] <= res_q;
					pc_q <= next_q;
				end
				ST_OUT: begin
					if (out_load) begin
						out_q.read_word_out <= (req_q.action == ACT_READ) ? mem_rdata_q : 32'd0;
						out_q.is_halted     <= halt_q;
						if (req_q.action == ACT_EXEC && !halt_or_skip_q) begin
							out_q.exec_pc      <= exec_pc_q;
							out_q.next_pc      <= next_q;
							out_q.reg_written  <= wr_q;
							out_q.dest_reg     <= wr_q ? rd_q : 4'd0;
							out_q.dest_value   <= wr_q ? res_q : 32'd0;
							out_q.divide_fault <= fault_q;
						end else begin
							out_q.exec_pc      <= pc_q;
							out_q.next_pc      <= pc_q;
							out_q.reg_written  <= 1'b0;
							out_q.dest_reg     <= 4'd0;
							out_q.dest_value   <= 32'd0;
							out_q.divide_fault <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// operand capture at decode, executed pc and halted-on-entry mark
	always_ff @(posedge clk) begin
		if (state_q == ST_DECODE) begin
			a_q  <= regs_q[mem_rdata_q[21:18]];
			b_q  <= regs_q[mem_rdata_q[17:14]];
			st_q <= regs_q[mem_rdata_q[25:22]];
			exec_pc_q <= pc_q;
			halt_or_skip_q <= halt_q;
		end
	end
endmodule
`default_nettype wire
